>>> rtl/ssv_pkg.sv
package ssv_pkg;

    localparam int VAL_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int SEG_SIZE   = 32768;
    localparam int SEG_BITS   = 15;
    localparam int SQRT_MAX   = 65536;
    localparam int FLAG_BITS  = 16;
    localparam int MAX_SP     = 8192;
    localparam int SP_BITS    = 13;
    localparam int CNT_W      = SP_BITS + 1;
    localparam int CUR_W      = 18;
    localparam int SQRT_STEPS = 16;

    localparam logic [VAL_W-1:0] LIMIT_RESET = 32'd1000000000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOAD,
        PH_SCAN,
        PH_DONE
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQRT,
        ST_FILL,
        ST_SS_CHK,
        ST_SS_TST,
        ST_SS_MARK,
        ST_NEXT,
        ST_LD_BEGIN,
        ST_LD_MUL,
        ST_LD_TST,
        ST_LD_END,
        ST_LD_CLR,
        ST_LD_KCHK,
        ST_LD_KWAIT,
        ST_LD_MARK,
        ST_SC_RD,
        ST_SC_TST
    } t_state;

endpackage

>>> rtl/ssv_isqrt.sv
module ssv_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ssv_pkg::VAL_W-1:0]  i_x,
    output logic                       o_done,
    output logic [ssv_pkg::ROOT_W-1:0] o_root
);
    import ssv_pkg::*;

    // Digit-by-digit square root: two radicand bits per cycle.
    logic [VAL_W-1:0] r_op, n_op;
    logic [VAL_W-1:0] r_res, n_res;
    logic [VAL_W-1:0] r_one, n_one;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [VAL_W:0]   sum;

    always_comb begin
        n_op   = r_op;
        n_res  = r_res;
        n_one  = r_one;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        sum    = {1'b0, r_res} + {1'b0, r_one};
        if (i_start) begin
            n_op  = i_x;
            n_res = '0;
            n_one = VAL_W'(1) << (VAL_W - 2);
            n_cnt = 5'(SQRT_STEPS);
            n_run = 1'b1;
        end else if (r_run) begin
            if ({1'b0, r_op} >= sum) begin
                n_op  = r_op - sum[VAL_W-1:0];
                n_res = (r_res >> 1) + r_one;
            end else begin
                n_res = r_res >> 1;
            end
            n_one = r_one >> 2;
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op  <= n_op;
        r_res <= n_res;
        r_one <= n_one;
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

>>> rtl/segmented_prime_sieve_top.sv
// Steps: a pull that continues a segment scans odd candidates until one is still set in the bitmap.
// A new segment first loads sieving primes from the root candidates, fills the bitmap and crosses
// off each prime's odd multiples; a restart first computes the root and sieves the small-prime flags.
// Reset is synchronous, active low; it sets the limit to 1000000000 and the block to idle.
// Each result is shown for one cycle with o_valid; the receiver cannot stall.
module segmented_prime_sieve_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_restart,
    input  logic                      i_cfg_we,
    input  logic [ssv_pkg::VAL_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic [ssv_pkg::VAL_W-1:0] o_prime_value,
    output logic                      o_found
);
    import ssv_pkg::*;

    // Control and enumeration state.
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [VAL_W-1:0]   r_limit;
    logic [VAL_W-1:0]   r_eff_end, n_eff_end;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [8:0]         r_i, n_i;
    logic [16:0]        r_j, n_j;
    logic [VAL_W:0]     r_base, n_base;
    logic [VAL_W:0]     r_cand, n_cand;
    logic [16:0]        r_sc, n_sc;
    logic [33:0]        r_prod, n_prod;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [VAL_W-1:0]   r_top, n_top;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [CUR_W-1:0]   r_step, n_step;
    logic [SEG_BITS:0]  r_clr, n_clr;
    logic               r_idx_ok, n_idx_ok;
    logic               r_out_stb, n_out_stb;
    logic [VAL_W-1:0]   r_out_val, n_out_val;
    logic               r_out_found, n_out_found;

    // Square-root unit.
    logic               sq_start;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;

    // Memory ports.
    logic                 f_we, f_wdata, f_rdata;
    logic [FLAG_BITS-1:0] f_waddr, f_raddr;
    logic                 p_we;
    logic [ROOT_W-1:0]    p_rdata;
    logic                 ofs_we;
    logic [SP_BITS-1:0]   ofs_waddr;
    logic [VAL_W-1:0]     ofs_wdata, ofs_rdata;
    logic                 b_we, b_wdata, b_rdata;
    logic [SEG_BITS-1:0]  b_waddr, b_raddr;

    logic [17:0]          ii;
    logic [VAL_W:0]       seg_last;
    logic [VAL_W:0]       idx;
    logic [VAL_W-1:0]     prod_m1;

    ssv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_limit),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Small-prime flags, one per number up to the root.
    logic flag_mem [SQRT_MAX];
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            flag_mem[f_waddr] <= f_wdata;
        end
        f_rdata <= flag_mem[f_raddr];
    end

    // Odd sieving primes and the offset of each one's next odd multiple.
    logic [ROOT_W-1:0] prime_mem [MAX_SP];
    logic [VAL_W-1:0]  ofs_mem [MAX_SP];
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            prime_mem[r_count[SP_BITS-1:0]] <= r_sc[ROOT_W-1:0];
        end
        if (ofs_we) begin
            ofs_mem[ofs_waddr] <= ofs_wdata;
        end
        p_rdata   <= prime_mem[r_k[SP_BITS-1:0]];
        ofs_rdata <= ofs_mem[r_k[SP_BITS-1:0]];
    end

    // Segment bitmap: a set bit means the number is still a prime candidate.
    logic bmp_mem [SEG_SIZE];
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            bmp_mem[b_waddr] <= b_wdata;
        end
        b_rdata <= bmp_mem[b_raddr];
    end

    assign ii       = {9'b0, r_i} * {9'b0, r_i};
    assign seg_last = r_base + (VAL_W+1)'(SEG_SIZE - 1);
    assign idx      = r_cand - r_base;
    assign prod_m1  = r_prod[VAL_W-1:0] - VAL_W'(1);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_eff_end   = r_eff_end;
        n_root      = r_root;
        n_i         = r_i;
        n_j         = r_j;
        n_base      = r_base;
        n_cand      = r_cand;
        n_sc        = r_sc;
        n_prod      = r_prod;
        n_count     = r_count;
        n_top       = r_top;
        n_k         = r_k;
        n_cur       = r_cur;
        n_step      = r_step;
        n_clr       = r_clr;
        n_idx_ok    = r_idx_ok;
        n_out_stb   = 1'b0;
        n_out_val   = r_out_val;
        n_out_found = r_out_found;
        sq_start    = 1'b0;
        f_we        = 1'b0;
        f_waddr     = r_j[FLAG_BITS-1:0];
        f_wdata     = 1'b1;
        f_raddr     = r_sc[FLAG_BITS-1:0];
        p_we        = 1'b0;
        ofs_we      = 1'b0;
        ofs_waddr   = r_count[SP_BITS-1:0];
        ofs_wdata   = r_prod[VAL_W-1:0] - r_base[VAL_W-1:0];
        b_we        = 1'b0;
        b_waddr     = r_clr[SEG_BITS-1:0];
        b_wdata     = 1'b1;
        b_raddr     = idx[SEG_BITS-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_restart || r_phase == PH_IDLE) begin
                        n_eff_end = r_limit;
                        sq_start  = 1'b1;
                        n_state   = ST_SQRT;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    n_root  = sq_root;
                    n_j     = '0;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                f_we = 1'b1;
                if (r_j[ROOT_W-1:0] == r_root) begin
                    n_i     = 9'd2;
                    n_state = ST_SS_CHK;
                end else begin
                    n_j = r_j + 17'd1;
                end
            end
            ST_SS_CHK: begin
                f_raddr = {7'b0, r_i};
                if (ii <= {2'b0, r_root}) begin
                    n_state = ST_SS_TST;
                end else begin
                    n_base  = '0;
                    n_cand  = (VAL_W+1)'(3);
                    n_sc    = 17'd2;
                    n_count = '0;
                    n_phase = PH_LOAD;
                    if (r_eff_end >= VAL_W'(2)) begin
                        n_out_stb   = 1'b1;
                        n_out_val   = VAL_W'(2);
                        n_out_found = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_SS_TST: begin
                if (f_rdata) begin
                    n_j     = ii[16:0];
                    n_state = ST_SS_MARK;
                end else begin
                    n_i     = r_i + 9'd1;
                    n_state = ST_SS_CHK;
                end
            end
            ST_SS_MARK: begin
                f_we    = 1'b1;
                f_wdata = 1'b0;
                n_j     = r_j + {8'b0, r_i};
                if ((r_j + {8'b0, r_i}) > {1'b0, r_root}) begin
                    n_i     = r_i + 9'd1;
                    n_state = ST_SS_CHK;
                end
            end
            ST_NEXT: begin
                priority if (r_phase == PH_SCAN) begin
                    n_state = ST_SC_RD;
                end else if (r_phase == PH_LOAD) begin
                    n_state = ST_LD_BEGIN;
                end else begin
                    n_phase     = PH_DONE;
                    n_out_stb   = 1'b1;
                    n_out_val   = '0;
                    n_out_found = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_LD_BEGIN: begin
                if (r_base > {1'b0, r_eff_end}) begin
                    n_phase = PH_DONE;
                    n_state = ST_NEXT;
                end else begin
                    n_top   = (seg_last > {1'b0, r_eff_end}) ? r_eff_end
                                                             : seg_last[VAL_W-1:0];
                    n_state = ST_LD_MUL;
                end
            end
            ST_LD_MUL: begin
                n_prod  = {17'b0, r_sc} * {17'b0, r_sc};
                n_state = ST_LD_TST;
            end
            ST_LD_TST: begin
                if (r_prod > {2'b0, r_top}) begin
                    n_state = ST_LD_END;
                end else if (f_rdata && r_sc != 17'd2) begin
                    if (r_count[SP_BITS]) begin
                        // Sieving store full: stop just below this prime's square.
                        n_eff_end = prod_m1;
                        if (r_top > prod_m1) begin
                            n_top = prod_m1;
                        end
                        n_state = ST_LD_END;
                    end else begin
                        p_we    = 1'b1;
                        ofs_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_sc    = r_sc + 17'd1;
                        n_state = ST_LD_MUL;
                    end
                end else begin
                    n_sc    = r_sc + 17'd1;
                    n_state = ST_LD_MUL;
                end
            end
            ST_LD_END: begin
                if (r_base > {1'b0, r_eff_end}) begin
                    n_phase = PH_DONE;
                    n_state = ST_NEXT;
                end else begin
                    n_clr   = '0;
                    n_state = ST_LD_CLR;
                end
            end
            ST_LD_CLR: begin
                b_we  = 1'b1;
                n_clr = r_clr + (SEG_BITS+1)'(1);
                if (r_clr[SEG_BITS-1:0] == SEG_BITS'(SEG_SIZE - 1)) begin
                    n_k     = '0;
                    n_state = ST_LD_KCHK;
                end
            end
            ST_LD_KCHK: begin
                if (r_k == r_count) begin
                    n_phase = PH_SCAN;
                    n_state = ST_SC_RD;
                end else begin
                    n_state = ST_LD_KWAIT;
                end
            end
            ST_LD_KWAIT: begin
                n_cur   = ofs_rdata[CUR_W-1:0];
                n_step  = {1'b0, p_rdata, 1'b0};
                n_state = ST_LD_MARK;
            end
            ST_LD_MARK: begin
                if (r_cur < CUR_W'(SEG_SIZE)) begin
                    b_we    = 1'b1;
                    b_waddr = r_cur[SEG_BITS-1:0];
                    b_wdata = 1'b0;
                    n_cur   = r_cur + r_step;
                end else begin
                    ofs_we    = 1'b1;
                    ofs_waddr = r_k[SP_BITS-1:0];
                    ofs_wdata = VAL_W'(r_cur - CUR_W'(SEG_SIZE));
                    n_k       = r_k + CNT_W'(1);
                    n_state   = ST_LD_KCHK;
                end
            end
            ST_SC_RD: begin
                if (r_cand > {1'b0, r_top}) begin
                    n_base  = r_base + (VAL_W+1)'(SEG_SIZE);
                    n_phase = ((r_base + (VAL_W+1)'(SEG_SIZE)) > {1'b0, r_eff_end})
                              ? PH_DONE : PH_LOAD;
                    n_state = ST_NEXT;
                end else begin
                    n_idx_ok = idx < (VAL_W+1)'(SEG_SIZE);
                    n_state  = ST_SC_TST;
                end
            end
            ST_SC_TST: begin
                n_cand = r_cand + (VAL_W+1)'(2);
                if (r_idx_ok && b_rdata) begin
                    n_out_stb   = 1'b1;
                    n_out_val   = r_cand[VAL_W-1:0];
                    n_out_found = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_SC_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A configuration write sets the phase back to idle, so the next pull restarts.
        if (i_cfg_we) begin
            n_phase = PH_IDLE;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Enumeration registers; a configuration write loads the limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_limit   <= LIMIT_RESET;
            r_eff_end <= '0;
            r_base    <= '0;
            r_cand    <= (VAL_W+1)'(3);
            r_sc      <= 17'd2;
            r_count   <= '0;
            r_top     <= '0;
            r_out_stb <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_eff_end <= n_eff_end;
            r_base    <= n_base;
            r_cand    <= n_cand;
            r_sc      <= n_sc;
            r_count   <= n_count;
            r_top     <= n_top;
            r_out_stb <= n_out_stb;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
        r_root      <= n_root;
        r_i         <= n_i;
        r_j         <= n_j;
        r_prod      <= n_prod;
        r_k         <= n_k;
        r_cur       <= n_cur;
        r_step      <= n_step;
        r_clr       <= n_clr;
        r_idx_ok    <= n_idx_ok;
        r_out_val   <= n_out_val;
        r_out_found <= n_out_found;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_out_stb;
    assign o_prime_value = r_out_val;
    assign o_found       = r_out_found;

`ifndef ASSERT_OFF
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while sequencer still busy");
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_prime_value == '0))
        else $error("not-found result carries a nonzero value");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SP))
        else $error("sieving prime count exceeds store depth");
    a_scan_in_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SC_TST) |-> r_idx_ok)
        else $error("scan candidate outside current segment");
`endif

endmodule

>>> dv/segmented_prime_sieve_top_tb.sv
`timescale 1ns / 1ps

// Prime sequence tracker: mirrors the segmented sieve at the word level and
// holds the primes (or not-found words) that the block still owes.
class prime_sequence_board;
    typedef enum int {
        SQ_IDLE,
        SQ_TWO,
        SQ_LOAD,
        SQ_SCAN,
        SQ_DONE
    } t_seq_phase;

    typedef struct {
        logic [ssv_pkg::VAL_W-1:0] value;
        logic                      found;
    } t_prime_word;

    t_prime_word pending_primes[$];
    int unsigned mismatches;

    logic [ssv_pkg::VAL_W-1:0] limit_reg;
    bit                        root_flags[ssv_pkg::SQRT_MAX];
    int unsigned               odd_primes[ssv_pkg::MAX_SP];
    longint unsigned           cross_offsets[ssv_pkg::MAX_SP];
    bit                        seg_open[ssv_pkg::SEG_SIZE];
    longint unsigned           seg_base;
    longint unsigned           next_cand;
    longint unsigned           root_cand;
    int unsigned               odd_count;
    t_seq_phase                seq_phase;
    longint unsigned           run_end;
    longint unsigned           seg_last;

    function new();
        limit_reg  = ssv_pkg::LIMIT_RESET;
        seq_phase  = SQ_IDLE;
        mismatches = 0;
    endfunction

    function void set_limit(logic [ssv_pkg::VAL_W-1:0] v);
        limit_reg = v;
        seq_phase = SQ_IDLE;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Restart: find the primes up to the root of the effective limit.
    function void begin_run();
        longint unsigned cap;
        longint unsigned root;
        cap = longint'(ssv_pkg::SQRT_MAX) * ssv_pkg::SQRT_MAX - 1;
        run_end = 64'(limit_reg);
        if (run_end > cap) run_end = cap;
        root = isqrt(run_end);
        if (root > ssv_pkg::SQRT_MAX - 1) root = ssv_pkg::SQRT_MAX - 1;
        for (longint unsigned i = 0; i <= root; i++) root_flags[i] = 1'b1;
        for (longint unsigned i = 2; i * i <= root; i++)
            if (root_flags[i])
                for (longint unsigned j = i * i; j <= root; j += i) root_flags[j] = 1'b0;
        seg_base  = 0;
        next_cand = 3;
        root_cand = 2;
        odd_count = 0;
        seq_phase = (run_end >= 2) ? SQ_TWO : SQ_LOAD;
    endfunction

    function void sieve_segment();
        longint unsigned top;
        longint unsigned j;
        longint unsigned s;
        if (seg_base > run_end) begin
            seq_phase = SQ_DONE;
            return;
        end
        top = seg_base + ssv_pkg::SEG_SIZE - 1;
        if (top > run_end) top = run_end;
        while (root_cand * root_cand <= top) begin
            s = root_cand;
            if (s < ssv_pkg::SQRT_MAX && root_flags[s] && s != 2) begin
                if (odd_count >= ssv_pkg::MAX_SP) begin
                    run_end = s * s - 1;
                    if (top > run_end) top = run_end;
                    break;
                end
                odd_primes[odd_count]    = 32'(s);
                cross_offsets[odd_count] = s * s - seg_base;
                odd_count++;
            end
            root_cand++;
        end
        if (seg_base > run_end) begin
            seq_phase = SQ_DONE;
            return;
        end
        foreach (seg_open[i]) seg_open[i] = 1'b1;
        for (int unsigned k = 0; k < odd_count; k++) begin
            j = cross_offsets[k];
            while (j < ssv_pkg::SEG_SIZE) begin
                seg_open[j] = 1'b0;
                j += 2 * odd_primes[k];
            end
            cross_offsets[k] = j - ssv_pkg::SEG_SIZE;
        end
        seg_last  = top;
        seq_phase = SQ_SCAN;
    endfunction

    function t_prime_word pull_prime();
        t_prime_word w;
        longint unsigned c;
        w.value = '0;
        w.found = 1'b0;
        if (seq_phase == SQ_TWO) begin
            seq_phase = SQ_LOAD;
            w.value   = 2;
            w.found   = 1'b1;
            return w;
        end
        forever begin
            if (seq_phase == SQ_SCAN) begin
                while (next_cand <= seg_last) begin
                    c = next_cand;
                    next_cand += 2;
                    if (c - seg_base < ssv_pkg::SEG_SIZE && seg_open[c - seg_base]) begin
                        w.value = c[31:0];
                        w.found = 1'b1;
                        return w;
                    end
                end
                seg_base += ssv_pkg::SEG_SIZE;
                seq_phase = (seg_base > run_end) ? SQ_DONE : SQ_LOAD;
            end else if (seq_phase == SQ_LOAD) begin
                sieve_segment();
            end else begin
                seq_phase = SQ_DONE;
                return w;
            end
        end
    endfunction

    function void note_pull(bit restart);
        t_prime_word w;
        if (restart || seq_phase == SQ_IDLE) begin_run();
        w = pull_prime();
        pending_primes = {pending_primes, w};
    endfunction

    function void check_word(logic [ssv_pkg::VAL_W-1:0] value, logic found);
        t_prime_word w;
        if (pending_primes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: value %0d found %0b", value, found);
            return;
        end
        w = pending_primes.pop_front();
        if (value !== w.value || found !== w.found) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected value %0d found %0b, got value %0d found %0b",
                         w.value, w.found, value, found);
        end
    endfunction
endclass

module segmented_prime_sieve_top_tb;
    import ssv_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_restart;
    logic             i_cfg_we;
    logic [VAL_W-1:0] i_cfg_data;
    logic             o_valid;
    logic [VAL_W-1:0] o_prime_value;
    logic             o_found;

    prime_sequence_board primes = new();

    // Idle gaps between pulls are enabled for most of the run and turned off at the end.
    bit gaps_on;
    int unsigned pull_total;

    segmented_prime_sieve_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_restart     (i_restart),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_prime_value (o_prime_value),
        .o_found       (o_found)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Every result word is taken at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) primes.check_word(o_prime_value, o_found);
    end

    // Raise start with the restart bit and hold it until the block takes the word.
    // Start is left high, so back-to-back pulls never drop it for a cycle.
    task automatic pull(bit restart);
        start     <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (busy);
        primes.note_pull(restart);
        pull_total++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start     <= 1'b0;
            i_restart <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Wait until every owed word has come back, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (primes.pending_primes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // The limit register is only written once the block has gone quiet.
    task automatic write_limit(logic [VAL_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        primes.set_limit(v);
    endtask

    task automatic pull_run(int unsigned count, int unsigned restart_pct);
        for (int unsigned n = 0; n < count; n++)
            pull($urandom_range(0, 99) < restart_pct);
    endtask

    initial begin
        start      = 1'b0;
        i_restart  = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        gaps_on    = 1'b0;
        pull_total = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A pull while idle acts as a restart, at the reset limit.
        pull(1'b0);
        pull(1'b0);
        pull(1'b0);
        pull(1'b1);
        pull(1'b0);
        // Limits below 2 give no prime at all; exhaustion keeps reporting not-found.
        write_limit(32'd0);
        pull(1'b0);
        pull(1'b1);
        write_limit(32'd1);
        pull(1'b0);
        pull(1'b0);
        // Limit 2 yields only the even prime, then not-found.
        write_limit(32'd2);
        pull(1'b0);
        pull(1'b0);
        pull(1'b0);
        write_limit(32'd3);
        pull(1'b0);
        pull(1'b0);
        pull(1'b0);
        pull(1'b1);
        // The all-ones limit needs a root of 65535, the top entry of the root store.
        write_limit(32'hFFFF_FFFF);
        pull(1'b0);
        pull(1'b0);
        pull(1'b0);

        // Walk a small limit to exhaustion, with idle gaps.
        gaps_on = 1'b1;
        write_limit(32'd3000);
        pull_run(450, 0);
        drain();

        // Random phases: small limits, mostly plain pulls with rare restarts.
        pull_total = 0;
        while (pull_total < 500) begin
            write_limit($urandom_range(5, 3000));
            if (pull_total > 400) gaps_on = 1'b0;
            pull_run($urandom_range(30, 250), 3);
            if ($urandom_range(0, 3) == 0) drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (primes.mismatches == 0 && primes.pending_primes.size() == 0) begin
            $display("segmented_prime_sieve_top_tb: PASS");
        end else begin
            $display("segmented_prime_sieve_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("segmented_prime_sieve_top_tb: FAIL");
        $finish;
    end
endmodule

>>> files.f
rtl/ssv_pkg.sv
rtl/ssv_isqrt.sv
rtl/segmented_prime_sieve_top.sv
dv/segmented_prime_sieve_top_tb.sv
